// ===== sv/exposure_fault_supervisor_top_macros.svh =====
// Assertion macros shared by the exposure fault supervisor RTL.
`ifndef EXPOSURE_FAULT_SUPERVISOR_TOP_MACROS_SVH
`define EXPOSURE_FAULT_SUPERVISOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check an expression at every clock edge outside reset.
`define EFS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check a consequence in the same cycle.
`define EFS_ASSERT_NOW(lbl, cond, conseq, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) cond |-> conseq) \
      else $error(msg);
// Check a consequence in the next cycle.
`define EFS_ASSERT_NEXT(lbl, cond, conseq, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) cond |=> conseq) \
      else $error(msg);
`else
`define EFS_ASSERT(lbl, prop, msg)
`define EFS_ASSERT_NOW(lbl, cond, conseq, msg)
`define EFS_ASSERT_NEXT(lbl, cond, conseq, msg)
`endif

`endif

// ===== sv/efs_pkg.sv =====
// Types, codes and constants of the exposure fault supervisor.
`default_nettype none
package efs_pkg;

   localparam int LVL_W = 12;
   localparam int MS_W  = 16;
   localparam int CNT_W = 16;
   localparam int IDX_W = 3;
   localparam int UNITS = 4;

   localparam int SAMPLE_BITS_DEF        = 12;
   localparam int KV_OVER_PERSIST_DEF    = 10;
   localparam int MA_OVER_PERSIST_DEF    = 10;
   localparam int KV_UNDER_PERSIST_DEF   = 10;
   localparam int MA_UNDER_PERSIST_DEF   = 10;

   localparam logic [MS_W-1:0] READY_SETTLE_MS = 16'd100;
   localparam logic [MS_W-1:0] CONT_SETTLE_MS  = 16'd50;
   localparam logic [MS_W-1:0] PULSE_SETTLE_MS = 16'd3;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [1:0] {
      PHASE_STANDBY  = 2'd0,
      PHASE_READY    = 2'd1,
      PHASE_EXPOSING = 2'd2,
      PHASE_OTHER    = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_INTERLOCK = 3'd1,
      ERR_TANK      = 3'd2,
      ERR_FILAMENT  = 3'd3,
      ERR_MA_OVER   = 3'd4,
      ERR_KV_OVER   = 3'd5,
      ERR_KV_UNDER  = 3'd6,
      ERR_MA_UNDER  = 3'd7
   } err_code_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_KV_HIGH       = 3'd0,
      CSR_KV_LOW        = 3'd1,
      CSR_MA_HIGH_CONT  = 3'd2,
      CSR_MA_HIGH_PULSE = 3'd3,
      CSR_MA_LOW        = 3'd4,
      CSR_FIL_LOW       = 3'd5,
      CSR_DC_LOW        = 3'd6
   } csr_idx_type;

   // LED bit positions
   localparam int LED_LOCK      = 0;
   localparam int LED_INTERLOCK = 1;
   localparam int LED_OVER_MA   = 2;
   localparam int LED_OVER_KV   = 3;

   // Persistence units: kV over, mA over, kV under, mA under
   localparam int U_KV_OVER  = 0;
   localparam int U_MA_OVER  = 1;
   localparam int U_KV_UNDER = 2;
   localparam int U_MA_UNDER = 3;

   typedef struct packed {
      logic [1:0]       phase;
      logic             pulsed_mode;
      logic [MS_W-1:0]  phase_ms;
      logic [MS_W-1:0]  pulse_ms;
      logic [LVL_W-1:0] kv_level;
      logic [LVL_W-1:0] ma_level;
      logic [LVL_W-1:0] fil_level;
      logic [LVL_W-1:0] dc_level;
      logic [1:0]       interlock_bits;
      logic [1:0]       hw_over_bits;
      logic             bypass;
      logic             clear_error;
   } req_type;

   typedef struct packed {
      logic [2:0] error_code;
      logic       shutdown;
      logic [3:0] led_bits;
   } rsp_type;

   typedef struct packed {
      logic [LVL_W-1:0] kv_high_limit;
      logic [LVL_W-1:0] kv_low_limit;
      logic [LVL_W-1:0] ma_high_cont_limit;
      logic [LVL_W-1:0] ma_high_pulse_limit;
      logic [LVL_W-1:0] ma_low_limit;
      logic [LVL_W-1:0] fil_low_limit;
      logic [LVL_W-1:0] dc_low_limit;
   } cfg_type;

endpackage
`default_nettype wire

// ===== sv/efs_req_if.sv =====
// Request channel of the exposure fault supervisor.
`default_nettype none
interface efs_req_if;
   logic             valid;
   logic             ready;
   efs_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/efs_rsp_if.sv =====
// Response channel of the exposure fault supervisor.
`default_nettype none
interface efs_rsp_if;
   logic             valid;
   logic             ready;
   efs_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/efs_csr_if.sv =====
// Register write channel of the exposure fault supervisor.
`default_nettype none
interface efs_csr_if;
   logic                         valid;
   logic                         ready;
   logic [efs_pkg::IDX_W-1:0]    index;
   logic [efs_pkg::LVL_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/efs_cfg_regs.sv =====
// Limit registers of the exposure fault supervisor.
`default_nettype none
module efs_cfg_regs #(
   parameter int SAMPLE_BITS = efs_pkg::SAMPLE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   efs_csr_if.sink          csr_chan,
   output efs_pkg::cfg_type cfg
);
   localparam int LW   = efs_pkg::LVL_W;
   localparam int LvlW = (SAMPLE_BITS < LW) ? SAMPLE_BITS : LW;

   logic [LvlW-1:0] kv_high_ff;
   logic [LvlW-1:0] kv_low_ff;
   logic [LvlW-1:0] ma_high_cont_ff;
   logic [LvlW-1:0] ma_high_pulse_ff;
   logic [LvlW-1:0] ma_low_ff;
   logic [LvlW-1:0] fil_low_ff;
   logic [LvlW-1:0] dc_low_ff;
   logic            wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kv_high_ff       <= '1;
         kv_low_ff        <= '0;
         ma_high_cont_ff  <= '1;
         ma_high_pulse_ff <= '1;
         ma_low_ff        <= '0;
         fil_low_ff       <= '0;
         dc_low_ff        <= '0;
      end else if (wr_en) begin
         unique case (efs_pkg::csr_idx_type'(csr_chan.index))
            efs_pkg::CSR_KV_HIGH:       kv_high_ff       <= csr_chan.data[LvlW-1:0];
            efs_pkg::CSR_KV_LOW:        kv_low_ff        <= csr_chan.data[LvlW-1:0];
            efs_pkg::CSR_MA_HIGH_CONT:  ma_high_cont_ff  <= csr_chan.data[LvlW-1:0];
            efs_pkg::CSR_MA_HIGH_PULSE: ma_high_pulse_ff <= csr_chan.data[LvlW-1:0];
            efs_pkg::CSR_MA_LOW:        ma_low_ff        <= csr_chan.data[LvlW-1:0];
            efs_pkg::CSR_FIL_LOW:       fil_low_ff       <= csr_chan.data[LvlW-1:0];
            efs_pkg::CSR_DC_LOW:        dc_low_ff        <= csr_chan.data[LvlW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Zero-extend the stored sample bits to the full level width
   assign cfg.kv_high_limit       = LW'(kv_high_ff);
   assign cfg.kv_low_limit        = LW'(kv_low_ff);
   assign cfg.ma_high_cont_limit  = LW'(ma_high_cont_ff);
   assign cfg.ma_high_pulse_limit = LW'(ma_high_pulse_ff);
   assign cfg.ma_low_limit        = LW'(ma_low_ff);
   assign cfg.fil_low_limit       = LW'(fil_low_ff);
   assign cfg.dc_low_limit        = LW'(dc_low_ff);

endmodule
`default_nettype wire

// ===== sv/efs_check_core.sv =====
// Fault checks, persistence counters and error latch of the supervisor.
`default_nettype none
`include "exposure_fault_supervisor_top_macros.svh"
module efs_check_core #(
   parameter int SAMPLE_BITS         = efs_pkg::SAMPLE_BITS_DEF,
   parameter int KV_OVER_PERSIST_MS  = efs_pkg::KV_OVER_PERSIST_DEF,
   parameter int MA_OVER_PERSIST_MS  = efs_pkg::MA_OVER_PERSIST_DEF,
   parameter int KV_UNDER_PERSIST_MS = efs_pkg::KV_UNDER_PERSIST_DEF,
   parameter int MA_UNDER_PERSIST_MS = efs_pkg::MA_UNDER_PERSIST_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  efs_pkg::req_type item,
   input  efs_pkg::cfg_type cfg,
   output efs_pkg::rsp_type result
);
   localparam int LW   = efs_pkg::LVL_W;
   localparam int LvlW = (SAMPLE_BITS < LW) ? SAMPLE_BITS : LW;
   localparam int CW   = efs_pkg::CNT_W;
   localparam int NU   = efs_pkg::UNITS;

   efs_pkg::err_code_type    err_ff, err_in;
   logic [3:0]               led_ff, led_in;
   logic [NU-1:0]            flag_ff, flag_in;
   logic [NU-1:0][CW-1:0]    cnt_ff, cnt_in, cnt_inc;
   logic [NU-1:0][CW-1:0]    persist_lim;
   efs_pkg::err_code_type    unit_code [NU];
   logic [3:0]               unit_led [NU];
   logic [NU-1:0]            beyond;
   logic [LvlW-1:0]          ma_hi;
   logic                     gate;
   logic                     under_gate;
   logic                     shut;
   logic                     halt;

   assign persist_lim[efs_pkg::U_KV_OVER]  = CW'(KV_OVER_PERSIST_MS);
   assign persist_lim[efs_pkg::U_MA_OVER]  = CW'(MA_OVER_PERSIST_MS);
   assign persist_lim[efs_pkg::U_KV_UNDER] = CW'(KV_UNDER_PERSIST_MS);
   assign persist_lim[efs_pkg::U_MA_UNDER] = CW'(MA_UNDER_PERSIST_MS);

   assign unit_code[efs_pkg::U_KV_OVER]  = efs_pkg::ERR_KV_OVER;
   assign unit_code[efs_pkg::U_MA_OVER]  = efs_pkg::ERR_MA_OVER;
   assign unit_code[efs_pkg::U_KV_UNDER] = efs_pkg::ERR_KV_UNDER;
   assign unit_code[efs_pkg::U_MA_UNDER] = efs_pkg::ERR_MA_UNDER;

   assign unit_led[efs_pkg::U_KV_OVER]  = 4'(1 << efs_pkg::LED_OVER_KV);
   assign unit_led[efs_pkg::U_MA_OVER]  = 4'(1 << efs_pkg::LED_OVER_MA);
   assign unit_led[efs_pkg::U_KV_UNDER] = 4'd0;
   assign unit_led[efs_pkg::U_MA_UNDER] = 4'd0;

   assign ma_hi = item.pulsed_mode ? cfg.ma_high_pulse_limit[LvlW-1:0]
                                   : cfg.ma_high_cont_limit[LvlW-1:0];

   assign beyond[efs_pkg::U_KV_OVER] =
      item.kv_level[LvlW-1:0] > cfg.kv_high_limit[LvlW-1:0];
   assign beyond[efs_pkg::U_MA_OVER] = item.ma_level[LvlW-1:0] > ma_hi;
   assign beyond[efs_pkg::U_KV_UNDER] =
      item.kv_level[LvlW-1:0] < cfg.kv_low_limit[LvlW-1:0];
   assign beyond[efs_pkg::U_MA_UNDER] =
      item.ma_level[LvlW-1:0] < cfg.ma_low_limit[LvlW-1:0];

   // settle windows for the level checks
   assign gate = item.pulsed_mode ?
                 (item.pulse_ms > efs_pkg::PULSE_SETTLE_MS &&
                  item.phase_ms > efs_pkg::READY_SETTLE_MS) :
                 (item.phase_ms > efs_pkg::CONT_SETTLE_MS);
   assign under_gate = !item.pulsed_mode && item.phase_ms > efs_pkg::READY_SETTLE_MS;

   always_comb begin
      for (int i = 0; i < NU; i++) begin
         cnt_inc[i] = (flag_ff[i] && cnt_ff[i] != efs_pkg::CNT_MAX) ?
                      cnt_ff[i] + CW'(1) : cnt_ff[i];
      end
      err_in  = item.clear_error ? efs_pkg::ERR_NONE : err_ff;
      led_in  = item.clear_error ? 4'd0 : led_ff;
      flag_in = flag_ff;
      cnt_in  = cnt_inc;
      shut    = 1'b0;
      halt    = 1'b0;
      if (err_in == efs_pkg::ERR_NONE && !item.bypass) begin
         if (item.phase == efs_pkg::PHASE_READY) begin
            if (item.phase_ms > efs_pkg::READY_SETTLE_MS) begin
               if (item.dc_level[LvlW-1:0] < cfg.dc_low_limit[LvlW-1:0]) begin
                  shut = 1'b1;
               end
               if (item.interlock_bits[0]) begin
                  err_in = efs_pkg::ERR_INTERLOCK;
                  led_in[efs_pkg::LED_LOCK] = 1'b1;
                  shut = 1'b1;
               end
               if (item.interlock_bits[1]) begin
                  err_in = efs_pkg::ERR_TANK;
                  led_in[efs_pkg::LED_INTERLOCK] = 1'b1;
                  shut = 1'b1;
               end
               if (item.fil_level[LvlW-1:0] < cfg.fil_low_limit[LvlW-1:0]) begin
                  err_in = efs_pkg::ERR_FILAMENT;
                  shut = 1'b1;
               end
            end
         end else if (item.phase == efs_pkg::PHASE_EXPOSING) begin
            if (item.hw_over_bits[0]) begin
               err_in = efs_pkg::ERR_MA_OVER;
               led_in[efs_pkg::LED_OVER_MA] = 1'b1;
               shut = 1'b1;
            end else if (item.hw_over_bits[1]) begin
               err_in = efs_pkg::ERR_KV_OVER;
               led_in[efs_pkg::LED_OVER_KV] = 1'b1;
               shut = 1'b1;
            end else if (gate) begin
               // units run in priority order; the first to latch ends the pass
               for (int i = 0; i < NU; i++) begin
                  if (!halt && (i < efs_pkg::U_KV_UNDER || under_gate)) begin
                     if (!beyond[i]) begin
                        flag_in[i] = 1'b0;
                        cnt_in[i]  = '0;
                     end else if (!flag_ff[i]) begin
                        flag_in[i] = 1'b1;
                        cnt_in[i]  = '0;
                     end else if (cnt_inc[i] >= persist_lim[i]) begin
                        err_in = unit_code[i];
                        led_in = led_in | unit_led[i];
                        shut   = 1'b1;
                        halt   = 1'b1;
                     end
                  end
               end
            end
         end
      end
      // drop a system interlock error once the interlock closes
      if (err_in == efs_pkg::ERR_INTERLOCK && !item.interlock_bits[0]) begin
         err_in = efs_pkg::ERR_NONE;
         led_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff  <= efs_pkg::ERR_NONE;
         led_ff  <= '0;
         flag_ff <= '0;
         cnt_ff  <= '0;
      end else if (step) begin
         err_ff  <= err_in;
         led_ff  <= led_in;
         flag_ff <= flag_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign result.error_code = err_in;
   assign result.shutdown   = shut;
   assign result.led_bits   = led_in;

   `EFS_ASSERT_NEXT(a_latch_holds,
      step && !item.clear_error && err_ff != efs_pkg::ERR_NONE && err_ff != efs_pkg::ERR_INTERLOCK,
      err_ff == $past(err_ff), "latched error changed without clear")
   `EFS_ASSERT_NOW(a_new_error_shuts,
      step && err_in != efs_pkg::ERR_NONE && (item.clear_error || err_ff == efs_pkg::ERR_NONE),
      result.shutdown, "new error latched without shutdown")
   `EFS_ASSERT_NEXT(a_idle_state_stable, !step,
      $stable(flag_ff) && $stable(cnt_ff) && $stable(err_ff) && $stable(led_ff),
      "supervisor state moved without a request")

endmodule
`default_nettype wire

// ===== sv/exposure_fault_supervisor_top.sv =====
// Top level of the exposure fault supervisor.
// Datapath: a request accepted into the request register is checked by the core and
//   its result captured in the response register.
// Throughput: one request per cycle while the response channel is not stalled, with the
//   single check stage between the request register and the response register.
// Reset (synchronous): clears the error latch, LEDs, persistence state, both
//   pipeline valids and restores the default limits.
`default_nettype none
`include "exposure_fault_supervisor_top_macros.svh"
module exposure_fault_supervisor_top #(
   parameter int SAMPLE_BITS         = efs_pkg::SAMPLE_BITS_DEF,
   parameter int KV_OVER_PERSIST_MS  = efs_pkg::KV_OVER_PERSIST_DEF,
   parameter int MA_OVER_PERSIST_MS  = efs_pkg::MA_OVER_PERSIST_DEF,
   parameter int KV_UNDER_PERSIST_MS = efs_pkg::KV_UNDER_PERSIST_DEF,
   parameter int MA_UNDER_PERSIST_MS = efs_pkg::MA_UNDER_PERSIST_DEF
) (
   input  logic        clock,
   input  logic        reset,
   efs_req_if.sink     req_chan,
   efs_rsp_if.source   rsp_chan,
   efs_csr_if.sink     csr_chan
);
   // request stage
   logic             s1_valid_ff;
   efs_pkg::req_type s1_data_ff;
   // response stage
   logic             rsp_valid_ff;
   efs_pkg::rsp_type rsp_data_ff;

   logic             advance;
   efs_pkg::rsp_type core_result;
   efs_pkg::cfg_type cfg;

   // Advance the held request into the response register when that register
   // is empty or being drained this cycle.
   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);

   // Take a new request whenever the request stage is empty or moving on.
   assign req_chan.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: no reset, qualified by the valids above.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_data_ff <= req_chan.data;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Limit regs, written through the CSR channel while idle by the user; not enforced.
   efs_cfg_regs #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_cfg (
      .clock   (clock),
      .reset   (reset),
      .csr_chan(csr_chan),
      .cfg     (cfg)
   );

   // Check logic and supervisor state; state commits only on advance.
   efs_check_core #(
      .SAMPLE_BITS        (SAMPLE_BITS),
      .KV_OVER_PERSIST_MS (KV_OVER_PERSIST_MS),
      .MA_OVER_PERSIST_MS (MA_OVER_PERSIST_MS),
      .KV_UNDER_PERSIST_MS(KV_UNDER_PERSIST_MS),
      .MA_UNDER_PERSIST_MS(MA_UNDER_PERSIST_MS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (s1_data_ff),
      .cfg   (cfg),
      .result(core_result)
   );

   // Hold both stages and the response while the output is stalled.
   `EFS_ASSERT_NEXT(a_stall_holds,
      s1_valid_ff && rsp_valid_ff && !rsp_chan.ready,
      s1_valid_ff && rsp_valid_ff && $stable(rsp_data_ff),
      "pipeline lost a request while stalled")

endmodule
`default_nettype wire
